// File: src/bba_pkg.sv
// Package for the bitmap block allocator.
// Holds map geometry, request and status codes and register indexes.
// Depends on nothing; used by every module of the block.
package bba_pkg;

   // Map geometry.
   localparam int MAX_BLOCKS = 65536;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = $clog2(MAP_WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);

   // Field widths fixed by the interface.
   localparam int BLOCK_W = 16;
   localparam int COUNT_W = 17;
   localparam int DELTA_W = 18;
   localparam int CSR_IDX_W = 1;

   // Search bound is capped by the map size and by the reach of a block number.
   localparam int LIM_TOP   = (MAX_BLOCKS < 65536) ? MAX_BLOCKS : 65536;
   localparam int COUNT_TOP = (MAX_BLOCKS < 131071) ? MAX_BLOCKS : 131071;

   // Request modes.
   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_MARK  = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NOFREE  = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_BLOCKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_FREE    = 1'd1;

endpackage

// File: src/bba_first_clear.sv
// Lowest clear bit finder for one map word.
// Depends on bba_pkg for the word width.
module bba_first_clear (
   input  logic [bba_pkg::WORD_BITS-1:0] word,
   output logic                          found,
   output logic [bba_pkg::BIT_W-1:0]     index
);
   import bba_pkg::*;

   // A word with any clear bit still holds a free block.
   assign found = ~&word;

   // Priority encoder: the last hit, walking downwards, is the lowest clear bit.
   always_comb begin
      index = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            index = BIT_W'(i);
         end
      end
   end

endmodule

// File: src/bitmap_block_allocator.sv
// Bitmap block allocator, first fit: one used bit per block in a 2048 x 32 map memory.
// Allocate scans the map one word a cycle (set by the single memory read port); free and mark
// do one read-modify-write of the addressed map word, and an ignored request or an allocate on
// an empty map goes straight to the result. A ready result waits while the output register
// stays full.
// Reset is synchronous; after it a clearing pass zeroes all 2048 map words, taking no item.
module bitmap_block_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [bba_pkg::BLOCK_W-1:0]   req_block_number,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bba_pkg::BLOCK_W-1:0]   rsp_allocated_block,
   output logic [1:0]                    rsp_status,
   output logic [bba_pkg::COUNT_W-1:0]   rsp_free_count,
   input  logic                          csr_wr_en,
   input  logic [bba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bba_pkg::COUNT_W-1:0]   csr_wdata
);
   import bba_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_MODIFY = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   localparam logic signed [DELTA_W-1:0] DELTA_MAX = 18'sh1FFFF;
   localparam logic signed [DELTA_W-1:0] DELTA_MIN = 18'sh20000;
   localparam logic signed [DELTA_W:0]   COUNT_TOP_S = (DELTA_W + 1)'(COUNT_TOP);

   logic [2:0]                  state_ff, state_in;
   logic [ADDR_W-1:0]           clr_ff, clr_in;
   logic [ADDR_W-1:0]           chk_ff, chk_in;
   logic [1:0]                  mode_ff, mode_in;
   logic [BLOCK_W-1:0]          num_ff, num_in;
   logic [BLOCK_W-1:0]          pend_block_ff, pend_block_in;
   logic [1:0]                  pend_status_ff, pend_status_in;
   logic signed [DELTA_W-1:0]   delta_ff, delta_in;
   logic [COUNT_W-1:0]          total_ff, init_free_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_W-1:0]          rsp_block_ff, rsp_block_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]          rsp_count_ff, rsp_count_in;

   // Map memory and its ports.
   logic [WORD_BITS-1:0]        map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0]        rd_data_ff;
   logic                        rd_en, wr_en;
   logic [ADDR_W-1:0]           rd_addr, wr_addr;
   logic [WORD_BITS-1:0]        wr_data;

   logic [COUNT_W-1:0]          lim;
   logic [ADDR_W-1:0]           req_word, num_word;
   logic [WORD_BITS-1:0]        bit_mask;
   logic                        fc_found;
   logic [BIT_W-1:0]            fc_index;
   logic [ADDR_W+BIT_W-1:0]     scan_n;
   logic [ADDR_W:0]             chk_next;
   logic [ADDR_W+BIT_W:0]       scan_next_base;
   logic signed [DELTA_W:0]     cnt_sum;
   logic [COUNT_W-1:0]          cnt_value;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= COUNT_W'(65536);
         init_free_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TOTAL_BLOCKS: total_ff     <= csr_wdata;
            CSR_INIT_FREE:    init_free_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Effective bound on block numbers.
   assign lim = (total_ff > COUNT_W'(LIM_TOP)) ? COUNT_W'(LIM_TOP) : total_ff;

   assign req_word = ADDR_W'(req_block_number >> BIT_W);
   assign num_word = ADDR_W'(num_ff >> BIT_W);
   assign bit_mask = WORD_BITS'(1) << num_ff[BIT_W-1:0];

   // Scan word decode.
   bba_first_clear u_first_clear (
      .word  (rd_data_ff),
      .found (fc_found),
      .index (fc_index)
   );

   assign scan_n         = {chk_ff, fc_index};
   assign chk_next       = (ADDR_W + 1)'(chk_ff) + (ADDR_W + 1)'(1);
   assign scan_next_base = {chk_next, BIT_W'(0)};

   // Reported free count: initial count plus delta, clamped.
   assign cnt_sum = $signed({2'b00, init_free_ff}) + $signed({delta_ff[DELTA_W-1], delta_ff});
   always_comb begin
      if (cnt_sum < 0) begin
         cnt_value = '0;
      end else if (cnt_sum > COUNT_TOP_S) begin
         cnt_value = COUNT_W'(COUNT_TOP);
      end else begin
         cnt_value = cnt_sum[COUNT_W-1:0];
      end
   end

   // Sequencer: clearing pass, request decode, word scan, read-modify-write, result.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      chk_in         = chk_ff;
      mode_in        = mode_ff;
      num_in         = num_ff;
      pend_block_in  = pend_block_ff;
      pend_status_in = pend_status_ff;
      delta_in       = delta_ff;
      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_block_in   = rsp_block_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in        = req_mode;
               num_in         = req_block_number;
               pend_block_in  = '0;
               pend_status_in = ST_IGNORED;
               state_in       = S_DONE;
               unique case (req_mode)
                  MODE_ALLOC: begin
                     if (lim == '0) begin
                        pend_status_in = ST_NOFREE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        chk_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  MODE_FREE: begin
                     if (req_block_number != '0 && {1'b0, req_block_number} < lim) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_word;
                        state_in = S_MODIFY;
                     end
                  end
                  MODE_MARK: begin
                     if ({1'b0, req_block_number} < lim) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_word;
                        state_in = S_MODIFY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SCAN: begin
            // Fetch the following word while this one is examined.
            rd_en   = 1'b1;
            rd_addr = chk_ff + ADDR_W'(1);
            priority if (fc_found) begin
               state_in = S_DONE;
               if (scan_n >= lim) begin
                  pend_block_in  = '0;
                  pend_status_in = ST_NOFREE;
               end else begin
                  wr_en          = 1'b1;
                  wr_addr        = chk_ff;
                  wr_data        = rd_data_ff | (WORD_BITS'(1) << fc_index);
                  pend_block_in  = BLOCK_W'(scan_n);
                  pend_status_in = ST_DONE;
                  if (delta_ff != DELTA_MIN) begin
                     delta_in = delta_ff - DELTA_W'(1);
                  end
               end
            end else if (scan_next_base >= lim) begin
               pend_block_in  = '0;
               pend_status_in = ST_NOFREE;
               state_in       = S_DONE;
            end else begin
               chk_in = chk_ff + ADDR_W'(1);
            end
         end
         S_MODIFY: begin
            wr_en          = 1'b1;
            wr_addr        = num_word;
            pend_block_in  = '0;
            pend_status_in = ST_DONE;
            state_in       = S_DONE;
            if (mode_ff == MODE_FREE) begin
               wr_data = rd_data_ff & ~bit_mask;
               if (delta_ff != DELTA_MAX) begin
                  delta_in = delta_ff + DELTA_W'(1);
               end
            end else begin
               wr_data = rd_data_ff | bit_mask;
            end
         end
         S_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_block_in  = pend_block_ff;
               rsp_status_in = pend_status_ff;
               rsp_count_in  = cnt_value;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         delta_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         delta_ff     <= delta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      chk_ff         <= chk_in;
      mode_ff        <= mode_in;
      num_ff         <= num_in;
      pend_block_ff  <= pend_block_in;
      pend_status_ff <= pend_status_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // Map memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_block = rsp_block_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_free_count      = rsp_count_ff;

   // No item is taken during the clearing pass.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("item accepted during clearing pass");

   // The map is written only by the clearing pass, a grant or a read-modify-write.
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_SCAN || state_ff == S_MODIFY))
      else $error("map written outside clear, scan or modify");

   // An accepted item always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted item dropped");

   // A read-modify-write always follows the read issued at acceptance.
   a_modify_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODIFY) |-> ($past(state_ff) == S_IDLE && $past(rd_en)))
      else $error("modify without a preceding read");

   // A nonzero granted block only comes with a completed request.
   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_allocated_block != '0) |-> (rsp_status == ST_DONE))
      else $error("granted block reported with failure status");

endmodule
